### rtl/core/rbd_pkg.sv
// ----------------------------------------------------------------------------
// Run-length byte decoder package
// Shared payload types, stream constants and controller/datapath interface.
// ----------------------------------------------------------------------------
package rbd_pkg;

    localparam int BYTE_W   = 8;
    localparam int COUNT_W  = 6;
    localparam int STATUS_W = 2;

    localparam logic [BYTE_W-1:0] END_MARKER  = 8'hC0;
    localparam logic [1:0]        HEADER_TAG  = 2'b11;

    localparam logic [STATUS_W-1:0] STATUS_BYTE  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_END   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_ERROR = 2'd2;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              end_of_input;
    } in_t;

    typedef struct packed {
        logic [BYTE_W-1:0]   out_byte;
        logic [STATUS_W-1:0] status;
        logic                last;
    } out_t;

    typedef enum logic [1:0] {
        KIND_INPUT,
        KIND_REPEAT,
        KIND_END,
        KIND_ERROR
    } out_kind_t;

    typedef struct packed {
        logic      load_count;
        logic      start_run;
        logic      step_run;
        logic      load_out;
        out_kind_t kind;
        logic      last;
    } cmd_t;

    typedef struct packed {
        logic is_end_marker;
        logic is_header;
        logic count_zero;
        logic count_one;
        logic remain_one;
        logic out_free;
    } sts_t;

endpackage

### rtl/core/rbd_datapath.sv
// ----------------------------------------------------------------------------
// Run-length byte decoder datapath
// Holds the repeat count, the run value and counter, and the output register.
// ----------------------------------------------------------------------------
module rbd_datapath (
    input  logic          aclk,
    input  logic          aresetn,
    input  rbd_pkg::in_t  s_data,
    input  rbd_pkg::cmd_t cmd,
    output rbd_pkg::sts_t sts,
    output logic          m_valid,
    input  logic          m_ready,
    output rbd_pkg::out_t m_data
);
    import rbd_pkg::*;

    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] remain_reg;
    logic [BYTE_W-1:0]  value_reg;
    logic               out_valid_reg;
    out_t               out_reg;
    out_t               out_next;

    always_comb begin
        out_next.last = cmd.last;
        unique case (cmd.kind)
            KIND_INPUT: begin
                out_next.out_byte = s_data.data_byte;
                out_next.status   = STATUS_BYTE;
            end
            KIND_REPEAT: begin
                out_next.out_byte = value_reg;
                out_next.status   = STATUS_BYTE;
            end
            KIND_END: begin
                out_next.out_byte = '0;
                out_next.status   = STATUS_END;
            end
            default: begin
                out_next.out_byte = '0;
                out_next.status   = STATUS_ERROR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_count) begin
            count_reg <= s_data.data_byte[COUNT_W-1:0];
        end
        if (cmd.start_run) begin
            value_reg  <= s_data.data_byte;
            remain_reg <= count_reg - COUNT_W'(1);
        end else if (cmd.step_run) begin
            remain_reg <= remain_reg - COUNT_W'(1);
        end
        if (cmd.load_out) begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign sts.is_end_marker = (s_data.data_byte == END_MARKER);
    assign sts.is_header     = (s_data.data_byte[BYTE_W-1 -: 2] == HEADER_TAG);
    assign sts.count_zero    = (count_reg == '0);
    assign sts.count_one     = (count_reg == COUNT_W'(1));
    assign sts.remain_one    = (remain_reg == COUNT_W'(1));
    assign sts.out_free      = !out_valid_reg || m_ready;

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

### rtl/core/rbd_controller.sv
// ----------------------------------------------------------------------------
// Run-length byte decoder controller
// Sequences literal, header, run and terminal handling of the byte stream.
// ----------------------------------------------------------------------------
module rbd_controller (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic          end_of_input,
    input  rbd_pkg::sts_t sts,
    output rbd_pkg::cmd_t cmd
);
    import rbd_pkg::*;

    typedef enum logic [1:0] {
        ST_ACCEPT,
        ST_AWAIT,
        ST_EMIT,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   fire;

    always_comb begin
        s_ready = 1'b0;
        unique case (state_reg)
            ST_ACCEPT, ST_AWAIT: s_ready = sts.out_free;
            ST_EMIT:             s_ready = 1'b0;
            default:             s_ready = 1'b1;
        endcase
    end

    assign fire = s_valid && s_ready;

    always_comb begin
        state_next     = state_reg;
        cmd.load_count = 1'b0;
        cmd.start_run  = 1'b0;
        cmd.step_run   = 1'b0;
        cmd.load_out   = 1'b0;
        cmd.kind       = KIND_INPUT;
        cmd.last       = 1'b1;
        unique case (state_reg)
            ST_ACCEPT: begin
                if (fire) begin
                    priority if (end_of_input) begin
                        cmd.load_out = 1'b1;
                        cmd.kind     = KIND_ERROR;
                        state_next   = ST_DONE;
                    end else if (sts.is_end_marker) begin
                        cmd.load_out = 1'b1;
                        cmd.kind     = KIND_END;
                        state_next   = ST_DONE;
                    end else if (sts.is_header) begin
                        cmd.load_count = 1'b1;
                        state_next     = ST_AWAIT;
                    end else begin
                        cmd.load_out = 1'b1;
                    end
                end
            end
            ST_AWAIT: begin
                if (fire) begin
                    priority if (end_of_input) begin
                        cmd.load_out = 1'b1;
                        cmd.kind     = KIND_ERROR;
                        state_next   = ST_DONE;
                    end else if (sts.count_zero) begin
                        state_next = ST_ACCEPT;
                    end else begin
                        cmd.load_out  = 1'b1;
                        cmd.start_run = 1'b1;
                        cmd.last      = sts.count_one;
                        state_next    = sts.count_one ? ST_ACCEPT : ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    cmd.step_run = 1'b1;
                    cmd.kind     = KIND_REPEAT;
                    cmd.last     = sts.remain_one;
                    if (sts.remain_one) begin
                        state_next = ST_ACCEPT;
                    end
                end
            end
            default: begin
                state_next = ST_DONE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_ACCEPT;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### rtl/core/rle_byte_decoder_top.sv
// ----------------------------------------------------------------------------
// Run-length byte decoder
// Expands a run-length coded byte stream into decoded bytes and a status.
//
// The s_ channel takes one compressed byte per transfer, or an end-of-input
// flag. The m_ channel gives decoded bytes with status and a last flag that
// marks the final result caused by each input transfer. The byte 0xC0 ends
// the stream with an end status; a byte with both top bits set is a run
// header whose low six bits count copies of the next byte. An end of input
// before the end marker gives an error status.
// An input transfer's first result is registered and appears in the cycle
// after it. Literals sustain one transfer per cycle while the receiver is
// ready; a header gives no result. A run holds the input while the run counter
// emits one copy per cycle from the output register while the receiver is ready.
// After the end marker or an error, input transfers are taken and dropped
// until reset. Reset returns the decoder to the start of a stream with the
// output register empty. When the receiver stalls, the output register holds
// its result and input or run progress waits for it.
// ----------------------------------------------------------------------------
module rle_byte_decoder_top (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  rbd_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output rbd_pkg::out_t m_data
);
    import rbd_pkg::*;

    cmd_t cmd;
    sts_t sts;

    rbd_controller u_controller (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .end_of_input (s_data.end_of_input),
        .sts          (sts),
        .cmd          (cmd)
    );

    rbd_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .sts     (sts),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
